// ===== sv/btc_pkg.sv =====
// ----------------------------------------------------------------------------
// btc_pkg
// Types and constants shared by the base-thousand time counter modules.
// ----------------------------------------------------------------------------
package btc_pkg;

   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_ADD  = 2'd1,
      FUNC_LOAD = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      UNIT_NS = 2'd0,
      UNIT_US = 2'd1,
      UNIT_MS = 2'd2,
      UNIT_S  = 2'd3
   } unit_type;

   typedef enum logic [1:0] {
      CSR_TICK_LENGTH = 2'd0,
      CSR_READ_UNIT   = 2'd1
   } csr_addr_type;

   localparam int unsigned DIGIT_W    = 10;
   localparam int unsigned DIGIT_BASE = 1000;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 10'd999;
   localparam logic [31:0] TICK_RESET = 32'd100;

   // floor(x / 10^(3k)) = (x * RECIP) >> SHIFT, exact for any 32-bit x
   localparam logic [32:0] RECIP_1E3 = 33'd274877907;
   localparam int unsigned SHIFT_1E3 = 38;
   localparam logic [32:0] RECIP_1E6 = 33'd4503599628;
   localparam int unsigned SHIFT_1E6 = 52;
   localparam logic [32:0] RECIP_1E9 = 33'd4611686019;
   localparam int unsigned SHIFT_1E9 = 62;

   localparam int unsigned QUO1_W = 23;
   localparam int unsigned QUO2_W = 13;
   localparam int unsigned QUO3_W = 3;

   localparam int unsigned SCALE_W = 30;
   localparam logic [SCALE_W-1:0] SCALE_NS = 30'd1000000000;
   localparam logic [SCALE_W-1:0] SCALE_US = 30'd1000000;
   localparam logic [SCALE_W-1:0] SCALE_MS = 30'd1000;
   localparam logic [SCALE_W-1:0] SCALE_S  = 30'd1;

   typedef struct packed {
      func_type           func;
      unit_type           pos;
      logic [DIGIT_W-1:0] ld_ns;
      logic [DIGIT_W-1:0] ld_us;
      logic [DIGIT_W-1:0] ld_ms;
      logic [31:0]        ld_sec;
   } op_type;

   typedef struct packed {
      logic s1;
      logic s2;
   } split_en_type;

   typedef struct packed {
      logic s4;
      logic s5;
   } total_en_type;

endpackage

// ===== sv/base_thousand_time_counter.sv =====
// ----------------------------------------------------------------------------
// base_thousand_time_counter
// Time counter held as ns/us/ms base-1000 digits plus a binary seconds
// count, with tick, add-at-unit and load operations.
//
//   channel  dir  handshake          word
//   req      in   req_valid/stall    func, amount, unit, load parts
//   rsp      out  rsp_valid/stall    parts, total in read unit, wrap flag
//   csr      in   csr_valid/ready    index, 32-bit write data
//
// One word per clock sustained while rsp_stall is low; each result leaves through the stages below in order.
// Stages: input, quotients, digit alignment, carry update of the counter,
// partial products, output. Only the carry update stage holds state.
// Reset clears the counter to zero, tick length to 100 ns and read unit to ns.
// A stalled rsp holds; bubbles in the pipe still close up and take new words.
// ----------------------------------------------------------------------------
module base_thousand_time_counter #(
   parameter int SECONDS_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_func,
   input  logic [31:0]                     req_amount,
   input  logic [1:0]                      req_unit,
   input  logic [btc_pkg::DIGIT_W-1:0]     req_load_nanos,
   input  logic [btc_pkg::DIGIT_W-1:0]     req_load_micros,
   input  logic [btc_pkg::DIGIT_W-1:0]     req_load_millis,
   input  logic [31:0]                     req_load_seconds,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [btc_pkg::DIGIT_W-1:0]     rsp_nanos_part,
   output logic [btc_pkg::DIGIT_W-1:0]     rsp_micros_part,
   output logic [btc_pkg::DIGIT_W-1:0]     rsp_millis_part,
   output logic [31:0]                     rsp_seconds_part,
   output logic [63:0]                     rsp_total_in_unit,
   output logic                            rsp_seconds_wrapped,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [31:0]                     csr_wdata
);

   localparam int SUM_W = ((SECONDS_BITS > 32) ? SECONDS_BITS : 32) + 1;

   logic [31:0]             tick_ff, tick_in;
   btc_pkg::unit_type       unit_ff, unit_in;

   logic [5:0]              valid_ff, valid_in;
   logic [5:0]              ready;

   btc_pkg::op_type         op_in, op0_ff, op1_ff, op2_ff;
   logic [31:0]             addend_in, addend0_ff;

   btc_pkg::split_en_type   split_en;
   btc_pkg::total_en_type   total_en;

   logic [btc_pkg::DIGIT_W-1:0] add_ns, add_us, add_ms;
   logic [31:0]                 add_sec;

   logic                        upd;
   logic [btc_pkg::DIGIT_W-1:0] ns_ff, us_ff, ms_ff, ns_in, us_in, ms_in;
   logic [SECONDS_BITS-1:0]     sec_ff, sec_in;
   logic                        wrap_ff, wrap_in;

   logic [btc_pkg::DIGIT_W:0]   sum_ns, sum_us, sum_ms;
   logic                        c_ns, c_us, c_ms;
   logic [SUM_W-1:0]            sum_sec;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      tick_in = tick_ff;
      unit_in = unit_ff;
      if (csr_valid) begin
         case (btc_pkg::csr_addr_type'(csr_index))
            btc_pkg::CSR_TICK_LENGTH: tick_in = csr_wdata;
            btc_pkg::CSR_READ_UNIT:   unit_in = btc_pkg::unit_type'(csr_wdata[1:0]);
            default:                  tick_in = tick_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= btc_pkg::TICK_RESET;
         unit_ff <= btc_pkg::UNIT_NS;
      end else begin
         tick_ff <= tick_in;
         unit_ff <= unit_in;
      end
   end

   // pipeline flow
   always_comb begin
      ready[5] = !valid_ff[5] || !rsp_stall;
      for (int k = 4; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < 6; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[5];

   // input stage: pick addend, clamp load digits
   always_comb begin
      op_in.func   = btc_pkg::func_type'(req_func);
      op_in.pos    = btc_pkg::unit_type'(req_unit);
      op_in.ld_ns  = (req_load_nanos  > btc_pkg::DIGIT_MAX) ? btc_pkg::DIGIT_MAX
                                                           : req_load_nanos;
      op_in.ld_us  = (req_load_micros > btc_pkg::DIGIT_MAX) ? btc_pkg::DIGIT_MAX
                                                           : req_load_micros;
      op_in.ld_ms  = (req_load_millis > btc_pkg::DIGIT_MAX) ? btc_pkg::DIGIT_MAX
                                                           : req_load_millis;
      op_in.ld_sec = req_load_seconds;
      addend_in    = req_amount;
      if (op_in.func == btc_pkg::FUNC_TICK) begin
         op_in.pos = btc_pkg::UNIT_NS;
         addend_in = tick_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         op0_ff     <= op_in;
         addend0_ff <= addend_in;
      end
      if (ready[1]) begin
         op1_ff <= op0_ff;
      end
      if (ready[2]) begin
         op2_ff <= op1_ff;
      end
   end

   assign split_en.s1 = ready[1];
   assign split_en.s2 = ready[2];

   btc_split u_split (
      .clock   (clock),
      .en      (split_en),
      .addend  (addend0_ff),
      .pos     (op0_ff.pos),
      .add_ns  (add_ns),
      .add_us  (add_us),
      .add_ms  (add_ms),
      .add_sec (add_sec)
   );

   // counter update: ripple carry over the three digits into seconds, or load of all parts
   assign upd = ready[3] && valid_ff[2];

   always_comb begin
      sum_ns  = (btc_pkg::DIGIT_W+1)'(ns_ff) + (btc_pkg::DIGIT_W+1)'(add_ns);
      c_ns    = sum_ns >= (btc_pkg::DIGIT_W+1)'(btc_pkg::DIGIT_BASE);
      sum_us  = (btc_pkg::DIGIT_W+1)'(us_ff) + (btc_pkg::DIGIT_W+1)'(add_us)
              + (btc_pkg::DIGIT_W+1)'(c_ns);
      c_us    = sum_us >= (btc_pkg::DIGIT_W+1)'(btc_pkg::DIGIT_BASE);
      sum_ms  = (btc_pkg::DIGIT_W+1)'(ms_ff) + (btc_pkg::DIGIT_W+1)'(add_ms)
              + (btc_pkg::DIGIT_W+1)'(c_us);
      c_ms    = sum_ms >= (btc_pkg::DIGIT_W+1)'(btc_pkg::DIGIT_BASE);
      sum_sec = SUM_W'(sec_ff) + SUM_W'(add_sec) + SUM_W'(c_ms);

      ns_in   = ns_ff;
      us_in   = us_ff;
      ms_in   = ms_ff;
      sec_in  = sec_ff;
      wrap_in = 1'b0;
      case (op2_ff.func)
         btc_pkg::FUNC_TICK, btc_pkg::FUNC_ADD: begin
            ns_in   = btc_pkg::DIGIT_W'(c_ns ? sum_ns - (btc_pkg::DIGIT_W+1)'(btc_pkg::DIGIT_BASE)
                                             : sum_ns);
            us_in   = btc_pkg::DIGIT_W'(c_us ? sum_us - (btc_pkg::DIGIT_W+1)'(btc_pkg::DIGIT_BASE)
                                             : sum_us);
            ms_in   = btc_pkg::DIGIT_W'(c_ms ? sum_ms - (btc_pkg::DIGIT_W+1)'(btc_pkg::DIGIT_BASE)
                                             : sum_ms);
            sec_in  = sum_sec[SECONDS_BITS-1:0];
            wrap_in = |sum_sec[SUM_W-1:SECONDS_BITS];
         end
         btc_pkg::FUNC_LOAD: begin
            ns_in  = op2_ff.ld_ns;
            us_in  = op2_ff.ld_us;
            ms_in  = op2_ff.ld_ms;
            sec_in = SECONDS_BITS'(op2_ff.ld_sec);
         end
         default: begin
            wrap_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ns_ff   <= '0;
         us_ff   <= '0;
         ms_ff   <= '0;
         sec_ff  <= '0;
         wrap_ff <= 1'b0;
      end else if (upd) begin
         ns_ff   <= ns_in;
         us_ff   <= us_in;
         ms_ff   <= ms_in;
         sec_ff  <= sec_in;
         wrap_ff <= wrap_in;
      end
   end

   assign total_en.s4 = ready[4];
   assign total_en.s5 = ready[5];

   btc_total #(
      .SECONDS_BITS (SECONDS_BITS)
   ) u_total (
      .clock           (clock),
      .en              (total_en),
      .read_unit       (unit_ff),
      .seconds         (sec_ff),
      .nanos           (ns_ff),
      .micros          (us_ff),
      .millis          (ms_ff),
      .wrapped         (wrap_ff),
      .nanos_part      (rsp_nanos_part),
      .micros_part     (rsp_micros_part),
      .millis_part     (rsp_millis_part),
      .seconds_part    (rsp_seconds_part),
      .total_in_unit   (rsp_total_in_unit),
      .seconds_wrapped (rsp_seconds_wrapped)
   );

endmodule

// ===== sv/btc_split.sv =====
// ----------------------------------------------------------------------------
// btc_split
// Splits a 32-bit addend into base-1000 digits and lines them up with the
// counter digits for the chosen unit. Two register stages.
// ----------------------------------------------------------------------------
module btc_split (
   input  logic                            clock,
   input  btc_pkg::split_en_type           en,
   input  logic [31:0]                     addend,
   input  btc_pkg::unit_type               pos,
   output logic [btc_pkg::DIGIT_W-1:0]     add_ns,
   output logic [btc_pkg::DIGIT_W-1:0]     add_us,
   output logic [btc_pkg::DIGIT_W-1:0]     add_ms,
   output logic [31:0]                     add_sec
);

   logic [60:0] prod1;
   logic [64:0] prod2;
   logic [64:0] prod3;

   logic [31:0]                 val_ff;
   btc_pkg::unit_type           pos_ff;
   logic [btc_pkg::QUO1_W-1:0]  q1_ff;
   logic [btc_pkg::QUO2_W-1:0]  q2_ff;
   logic [btc_pkg::QUO3_W-1:0]  q3_ff;

   logic [31:0]                 q1x;
   logic [btc_pkg::QUO1_W-1:0]  q2x;
   logic [btc_pkg::QUO2_W-1:0]  q3x;
   logic [btc_pkg::DIGIT_W-1:0] dig0;
   logic [btc_pkg::DIGIT_W-1:0] dig1;
   logic [btc_pkg::DIGIT_W-1:0] dig2;

   logic [btc_pkg::DIGIT_W-1:0] add_ns_in, add_us_in, add_ms_in;
   logic [31:0]                 add_sec_in;
   logic [btc_pkg::DIGIT_W-1:0] add_ns_ff, add_us_ff, add_ms_ff;
   logic [31:0]                 add_sec_ff;

   assign prod1 = 61'(addend) * 61'(btc_pkg::RECIP_1E3);
   assign prod2 = 65'(addend) * 65'(btc_pkg::RECIP_1E6);
   assign prod3 = 65'(addend) * 65'(btc_pkg::RECIP_1E9);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         val_ff <= addend;
         pos_ff <= pos;
         q1_ff  <= prod1[60:btc_pkg::SHIFT_1E3];
         q2_ff  <= prod2[64:btc_pkg::SHIFT_1E6];
         q3_ff  <= prod3[64:btc_pkg::SHIFT_1E9];
      end
   end

   assign q1x  = 32'(q1_ff) * 32'(btc_pkg::DIGIT_BASE);
   assign q2x  = btc_pkg::QUO1_W'(q2_ff) * btc_pkg::QUO1_W'(btc_pkg::DIGIT_BASE);
   assign q3x  = btc_pkg::QUO2_W'(q3_ff) * btc_pkg::QUO2_W'(btc_pkg::DIGIT_BASE);
   assign dig0 = btc_pkg::DIGIT_W'(val_ff - q1x);
   assign dig1 = btc_pkg::DIGIT_W'(q1_ff - q2x);
   assign dig2 = btc_pkg::DIGIT_W'(q2_ff - q3x);

   // align digits to the unit: higher part goes to seconds
   always_comb begin
      add_ns_in  = '0;
      add_us_in  = '0;
      add_ms_in  = '0;
      add_sec_in = val_ff;
      case (pos_ff)
         btc_pkg::UNIT_NS: begin
            add_ns_in  = dig0;
            add_us_in  = dig1;
            add_ms_in  = dig2;
            add_sec_in = 32'(q3_ff);
         end
         btc_pkg::UNIT_US: begin
            add_us_in  = dig0;
            add_ms_in  = dig1;
            add_sec_in = 32'(q2_ff);
         end
         btc_pkg::UNIT_MS: begin
            add_ms_in  = dig0;
            add_sec_in = 32'(q1_ff);
         end
         default: begin
            add_sec_in = val_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         add_ns_ff  <= add_ns_in;
         add_us_ff  <= add_us_in;
         add_ms_ff  <= add_ms_in;
         add_sec_ff <= add_sec_in;
      end
   end

   assign add_ns  = add_ns_ff;
   assign add_us  = add_us_ff;
   assign add_ms  = add_ms_ff;
   assign add_sec = add_sec_ff;

endmodule

// ===== sv/btc_total.sv =====
// ----------------------------------------------------------------------------
// btc_total
// Scales the counter to the read unit and holds the result word.
// Two register stages: partial products, then final sum.
// ----------------------------------------------------------------------------
module btc_total #(
   parameter int SECONDS_BITS = 32
) (
   input  logic                            clock,
   input  btc_pkg::total_en_type           en,
   input  btc_pkg::unit_type               read_unit,
   input  logic [SECONDS_BITS-1:0]         seconds,
   input  logic [btc_pkg::DIGIT_W-1:0]     nanos,
   input  logic [btc_pkg::DIGIT_W-1:0]     micros,
   input  logic [btc_pkg::DIGIT_W-1:0]     millis,
   input  logic                            wrapped,
   output logic [btc_pkg::DIGIT_W-1:0]     nanos_part,
   output logic [btc_pkg::DIGIT_W-1:0]     micros_part,
   output logic [btc_pkg::DIGIT_W-1:0]     millis_part,
   output logic [31:0]                     seconds_part,
   output logic [63:0]                     total_in_unit,
   output logic                            seconds_wrapped
);

   logic [63:0]                    sec_wide;
   logic [btc_pkg::SCALE_W-1:0]    scale;
   logic [btc_pkg::SCALE_W-1:0]    low_in;
   logic [63:0]                    prod_lo;
   logic [31:0]                    prod_hi_in;

   logic [61:0]                    prod_lo_ff;
   logic [31:0]                    prod_hi_ff;
   logic [btc_pkg::SCALE_W-1:0]    low_ff;
   logic [btc_pkg::DIGIT_W-1:0]    ns4_ff, us4_ff, ms4_ff;
   logic [31:0]                    sec4_ff;
   logic                           wrap4_ff;

   logic [63:0]                    total_in;
   logic [btc_pkg::DIGIT_W-1:0]    ns5_ff, us5_ff, ms5_ff;
   logic [31:0]                    sec5_ff;
   logic [63:0]                    total5_ff;
   logic                           wrap5_ff;

   assign sec_wide = 64'(seconds);

   always_comb begin
      case (read_unit)
         btc_pkg::UNIT_NS: begin
            scale  = btc_pkg::SCALE_NS;
            low_in = btc_pkg::SCALE_W'(millis) * btc_pkg::SCALE_US
                   + btc_pkg::SCALE_W'(micros) * btc_pkg::SCALE_MS
                   + btc_pkg::SCALE_W'(nanos);
         end
         btc_pkg::UNIT_US: begin
            scale  = btc_pkg::SCALE_US;
            low_in = btc_pkg::SCALE_W'(millis) * btc_pkg::SCALE_MS
                   + btc_pkg::SCALE_W'(micros);
         end
         btc_pkg::UNIT_MS: begin
            scale  = btc_pkg::SCALE_MS;
            low_in = btc_pkg::SCALE_W'(millis);
         end
         default: begin
            scale  = btc_pkg::SCALE_S;
            low_in = '0;
         end
      endcase
   end

   assign prod_lo    = 64'(sec_wide[31:0]) * 64'(scale);
   assign prod_hi_in = sec_wide[63:32] * 32'(scale);

   always_ff @(posedge clock) begin
      if (en.s4) begin
         prod_lo_ff <= prod_lo[61:0];
         prod_hi_ff <= prod_hi_in;
         low_ff     <= low_in;
         ns4_ff     <= nanos;
         us4_ff     <= micros;
         ms4_ff     <= millis;
         sec4_ff    <= sec_wide[31:0];
         wrap4_ff   <= wrapped;
      end
   end

   assign total_in = {prod_hi_ff, 32'd0} + 64'(prod_lo_ff) + 64'(low_ff);

   always_ff @(posedge clock) begin
      if (en.s5) begin
         ns5_ff    <= ns4_ff;
         us5_ff    <= us4_ff;
         ms5_ff    <= ms4_ff;
         sec5_ff   <= sec4_ff;
         total5_ff <= total_in;
         wrap5_ff  <= wrap4_ff;
      end
   end

   assign nanos_part      = ns5_ff;
   assign micros_part     = us5_ff;
   assign millis_part     = ms5_ff;
   assign seconds_part    = sec5_ff;
   assign total_in_unit   = total5_ff;
   assign seconds_wrapped = wrap5_ff;

endmodule

// ===== sv/btc_check.sv =====
// ----------------------------------------------------------------------------
// btc_check
// Port-level checks for the base-thousand time counter, bound to the top.
// ----------------------------------------------------------------------------
module btc_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [btc_pkg::DIGIT_W-1:0]     rsp_nanos_part,
   input logic [btc_pkg::DIGIT_W-1:0]     rsp_micros_part,
   input logic [btc_pkg::DIGIT_W-1:0]     rsp_millis_part,
   input logic [63:0]                     rsp_total_in_unit,
   input logic                            rsp_seconds_wrapped
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_nanos_part  < 10'(btc_pkg::DIGIT_BASE)) &&
                    (rsp_micros_part < 10'(btc_pkg::DIGIT_BASE)) &&
                    (rsp_millis_part < 10'(btc_pkg::DIGIT_BASE)))
      else $error("digit out of base-1000 range");

   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total_in_unit) &&
                                 $stable(rsp_seconds_wrapped))
      else $error("stalled result changed");

endmodule

bind base_thousand_time_counter btc_check u_btc_check (.*);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base-thousand time counter. A tracker class
// keeps its own copy of the ns/us/ms digits, the seconds count and the two
// registers. It predicts one readout per accepted request word and compares
// every accepted response word against the oldest prediction. Stimulus is a
// short directed set of edge cases followed by random phases. Each phase runs
// under its own tick length and read unit. Both channels idle in random
// bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import btc_pkg::*;

   localparam int SECONDS_BITS    = 32;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int PHASE_COUNT     = 8;
   localparam int WORDS_PER_PHASE = 75;
   localparam int END_WAIT        = 12;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [31:0]        amount;
      logic [1:0]         unit;
      logic [DIGIT_W-1:0] ld_ns;
      logic [DIGIT_W-1:0] ld_us;
      logic [DIGIT_W-1:0] ld_ms;
      logic [31:0]        ld_sec;
   } req_word_t;

   typedef struct packed {
      logic [DIGIT_W-1:0] ns_part;
      logic [DIGIT_W-1:0] us_part;
      logic [DIGIT_W-1:0] ms_part;
      logic [31:0]        sec_part;
      logic [63:0]        total;
      logic               wrapped;
   } readout_t;

   class time_value_tracker;
      logic [31:0]        tick_len;
      unit_type           read_unit;
      logic [DIGIT_W-1:0] ns_d;
      logic [DIGIT_W-1:0] us_d;
      logic [DIGIT_W-1:0] ms_d;
      logic [63:0]        sec;
      readout_t           expected_readouts[$];
      int                 errors;
      int                 checked;
      int                 wraps;
      int                 reg_writes;
      int                 op_seen[4];

      function new();
         tick_len   = TICK_RESET;
         read_unit  = UNIT_NS;
         ns_d       = '0;
         us_d       = '0;
         ms_d       = '0;
         sec        = '0;
         errors     = 0;
         checked    = 0;
         wraps      = 0;
         reg_writes = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
      endfunction

      function logic [63:0] sec_mask();
         return (64'd1 << SECONDS_BITS) - 64'd1;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] data);
         reg_writes++;
         if (idx == CSR_TICK_LENGTH) tick_len = data;
         else if (idx == CSR_READ_UNIT) read_unit = unit_type'(data[1:0]);
      endfunction

      function logic clamp_needed_digit(logic [DIGIT_W-1:0] d);
         return d > DIGIT_MAX;
      endfunction

      function logic carry_in(logic [63:0] amt, unit_type pos);
         logic [63:0] carry;
         logic [63:0] s;
         carry = amt;
         if (pos == UNIT_NS) begin
            s = ns_d + carry;
            ns_d = DIGIT_W'(s % DIGIT_BASE);
            carry = s / DIGIT_BASE;
         end
         if (pos <= UNIT_US) begin
            s = us_d + carry;
            us_d = DIGIT_W'(s % DIGIT_BASE);
            carry = s / DIGIT_BASE;
         end
         if (pos <= UNIT_MS) begin
            s = ms_d + carry;
            ms_d = DIGIT_W'(s % DIGIT_BASE);
            carry = s / DIGIT_BASE;
         end
         s = sec + carry;
         sec = s & sec_mask();
         return s > sec_mask();
      endfunction

      function logic [63:0] total_value();
         logic [63:0] t;
         t = sec;
         if (read_unit <= UNIT_MS) t = t * DIGIT_BASE + ms_d;
         if (read_unit <= UNIT_US) t = t * DIGIT_BASE + us_d;
         if (read_unit == UNIT_NS) t = t * DIGIT_BASE + ns_d;
         return t;
      endfunction

      function void apply_word(req_word_t w);
         readout_t r;
         logic     wrapped;
         wrapped = 1'b0;
         op_seen[w.func]++;
         case (w.func)
            FUNC_TICK: wrapped = carry_in({32'd0, tick_len}, UNIT_NS);
            FUNC_ADD:  wrapped = carry_in({32'd0, w.amount}, unit_type'(w.unit));
            FUNC_LOAD: begin
               ns_d = clamp_needed_digit(w.ld_ns) ? DIGIT_MAX : w.ld_ns;
               us_d = clamp_needed_digit(w.ld_us) ? DIGIT_MAX : w.ld_us;
               ms_d = clamp_needed_digit(w.ld_ms) ? DIGIT_MAX : w.ld_ms;
               sec  = {32'd0, w.ld_sec} & sec_mask();
            end
            default: wrapped = 1'b0;
         endcase
         r.ns_part  = ns_d;
         r.us_part  = us_d;
         r.ms_part  = ms_d;
         r.sec_part = sec[31:0];
         r.total    = total_value();
         r.wrapped  = wrapped;
         expected_readouts.push_back(r);
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void compare_readout(readout_t got);
         readout_t want;
         if (expected_readouts.size() == 0) begin
            $error("response word with no prediction pending");
            errors++;
            return;
         end
         want = expected_readouts.pop_front();
         checked++;
         if (want.wrapped) wraps++;
         check_field("nanos_part", want.ns_part, got.ns_part);
         check_field("micros_part", want.us_part, got.us_part);
         check_field("millis_part", want.ms_part, got.ms_part);
         check_field("seconds_part", want.sec_part, got.sec_part);
         check_field("total_in_unit", want.total, got.total);
         check_field("seconds_wrapped", want.wrapped, got.wrapped);
      endfunction

      function int outstanding();
         return expected_readouts.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = '0;
   logic [31:0]        req_amount = '0;
   logic [1:0]         req_unit = '0;
   logic [DIGIT_W-1:0] req_load_nanos = '0;
   logic [DIGIT_W-1:0] req_load_micros = '0;
   logic [DIGIT_W-1:0] req_load_millis = '0;
   logic [31:0]        req_load_seconds = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [DIGIT_W-1:0] rsp_nanos_part;
   logic [DIGIT_W-1:0] rsp_micros_part;
   logic [DIGIT_W-1:0] rsp_millis_part;
   logic [31:0]        rsp_seconds_part;
   logic [63:0]        rsp_total_in_unit;
   logic               rsp_seconds_wrapped;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   time_value_tracker tracker;
   bit                idling = 1'b1;
   int                rsp_hold_left = 0;

   base_thousand_time_counter #(.SECONDS_BITS(SECONDS_BITS)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_amount          (req_amount),
      .req_unit            (req_unit),
      .req_load_nanos      (req_load_nanos),
      .req_load_micros     (req_load_micros),
      .req_load_millis     (req_load_millis),
      .req_load_seconds    (req_load_seconds),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_nanos_part      (rsp_nanos_part),
      .rsp_micros_part     (rsp_micros_part),
      .rsp_millis_part     (rsp_millis_part),
      .rsp_seconds_part    (rsp_seconds_part),
      .rsp_total_in_unit   (rsp_total_in_unit),
      .rsp_seconds_wrapped (rsp_seconds_wrapped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            tracker.apply_word('{req_func, req_amount, req_unit, req_load_nanos,
                                 req_load_micros, req_load_millis, req_load_seconds});
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.compare_readout('{rsp_nanos_part, rsp_micros_part, rsp_millis_part,
                                      rsp_seconds_part, rsp_total_in_unit,
                                      rsp_seconds_wrapped});
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (idling && $urandom_range(0, 7) == 0) rsp_hold_left <= $urandom_range(1, 15);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic req_word_t word_of(logic [1:0] f, logic [31:0] amt, logic [1:0] u,
                                         logic [DIGIT_W-1:0] a, logic [DIGIT_W-1:0] b,
                                         logic [DIGIT_W-1:0] c, logic [31:0] s);
      return '{f, amt, u, a, b, c, s};
   endfunction

   function automatic logic [DIGIT_W-1:0] random_digit();
      if ($urandom_range(0, 7) == 0) return DIGIT_W'($urandom_range(990, 1023));
      return DIGIT_W'($urandom_range(0, 999));
   endfunction

   function automatic req_word_t random_word();
      req_word_t w;
      int        pick;
      w = word_of(2'($urandom_range(0, 3)), $urandom, 2'($urandom_range(0, 3)),
                  DIGIT_W'($urandom_range(0, 1023)), DIGIT_W'($urandom_range(0, 1023)),
                  DIGIT_W'($urandom_range(0, 1023)), $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         w.func = FUNC_TICK;
      end else if (pick < 75) begin
         w.func = FUNC_ADD;
         case ($urandom_range(0, 3))
            0: w.amount = $urandom_range(0, 1999);
            1: w.amount = $urandom_range(0, 999999);
            2: w.amount = $urandom;
            default: w.amount = 32'hFFFF_FFFF - $urandom_range(0, 2);
         endcase
      end else if (pick < 94) begin
         w.func  = FUNC_LOAD;
         w.ld_ns = random_digit();
         w.ld_us = random_digit();
         w.ld_ms = random_digit();
         case ($urandom_range(0, 2))
            0: w.ld_sec = 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: w.ld_sec = $urandom_range(0, 100);
            default: w.ld_sec = $urandom;
         endcase
      end else begin
         w.func = FUNC_UNUSED;
      end
      return w;
   endfunction

   task automatic send_word(input req_word_t w);
      if (idling && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= w.func;
      req_amount       <= w.amount;
      req_unit         <= w.unit;
      req_load_nanos   <= w.ld_ns;
      req_load_micros  <= w.ld_us;
      req_load_millis  <= w.ld_ms;
      req_load_seconds <= w.ld_sec;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_readouts();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   task automatic set_reg(input csr_addr_type idx, input logic [31:0] data);
      drain_readouts();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : main
      int hold_at;
      tracker = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset register values first
      send_word(word_of(FUNC_TICK, '0, UNIT_NS, '0, '0, '0, '0));
      send_word(word_of(FUNC_TICK, '1, UNIT_S, '1, '1, '1, '1));
      send_word(word_of(FUNC_UNUSED, $urandom, UNIT_US, 10'd5, 10'd6, 10'd7, $urandom));
      send_word(word_of(FUNC_ADD, '0, UNIT_NS, '0, '0, '0, '0));
      send_word(word_of(FUNC_ADD, '1, UNIT_NS, '0, '0, '0, '0));
      send_word(word_of(FUNC_ADD, '1, UNIT_US, '0, '0, '0, '0));
      send_word(word_of(FUNC_ADD, '1, UNIT_MS, '0, '0, '0, '0));
      send_word(word_of(FUNC_ADD, '1, UNIT_S, '0, '0, '0, '0));
      send_word(word_of(FUNC_LOAD, '0, UNIT_NS, '1, '1, '1, '1));
      send_word(word_of(FUNC_TICK, '0, UNIT_NS, '0, '0, '0, '0));
      send_word(word_of(FUNC_LOAD, '0, UNIT_NS, DIGIT_MAX, DIGIT_MAX, DIGIT_MAX, '1));
      send_word(word_of(FUNC_ADD, 32'd1, UNIT_NS, '0, '0, '0, '0));
      send_word(word_of(FUNC_LOAD, '1, UNIT_S, '0, '0, '0, '0));
      send_word(word_of(FUNC_LOAD, '0, UNIT_NS, 10'h155, 10'h2AA, 10'd1000, 32'h5555_AAAA));
      send_word(word_of(FUNC_ADD, 32'd1, UNIT_S, '0, '0, '0, '0));
      send_word(word_of(FUNC_UNUSED, '1, UNIT_S, '1, '1, '1, '1));

      set_reg(CSR_TICK_LENGTH, 32'hFFFF_FFFF);
      set_reg(CSR_READ_UNIT, 32'(UNIT_US));
      send_word(word_of(FUNC_TICK, '0, UNIT_NS, '0, '0, '0, '0));
      send_word(word_of(FUNC_TICK, '0, UNIT_NS, '0, '0, '0, '0));
      set_reg(CSR_READ_UNIT, 32'(UNIT_MS));
      send_word(word_of(FUNC_TICK, '0, UNIT_NS, '0, '0, '0, '0));
      set_reg(CSR_READ_UNIT, 32'(UNIT_S));
      send_word(word_of(FUNC_LOAD, '0, UNIT_NS, DIGIT_MAX, DIGIT_MAX, DIGIT_MAX, '1));
      send_word(word_of(FUNC_TICK, '0, UNIT_NS, '0, '0, '0, '0));
      set_reg(CSR_TICK_LENGTH, 32'd0);
      send_word(word_of(FUNC_TICK, '0, UNIT_NS, '0, '0, '0, '0));

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p % 6)
            0: set_reg(CSR_TICK_LENGTH, TICK_RESET);
            1: set_reg(CSR_TICK_LENGTH, 32'd0);
            2: set_reg(CSR_TICK_LENGTH, 32'hFFFF_FFFF);
            3: set_reg(CSR_TICK_LENGTH, 32'd1);
            4: set_reg(CSR_TICK_LENGTH, $urandom_range(1, 5000000));
            default: set_reg(CSR_TICK_LENGTH, $urandom);
         endcase
         set_reg(CSR_READ_UNIT, 32'(p % 4));
         if (p == PHASE_COUNT - 1) idling = 1'b0;
         hold_at = $urandom_range(5, WORDS_PER_PHASE - 5);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (i == hold_at) drain_readouts();
            send_word(random_word());
         end
      end

      drain_readouts();
      repeat (END_WAIT) @(posedge clock);
      if (tracker.outstanding() != 0) begin
         $error("%0d predicted readouts never arrived", tracker.outstanding());
         tracker.errors++;
      end
      $display("ran %0d ticks, %0d adds, %0d loads and %0d unused-op words",
               tracker.op_seen[FUNC_TICK], tracker.op_seen[FUNC_ADD],
               tracker.op_seen[FUNC_LOAD], tracker.op_seen[FUNC_UNUSED]);
      $display("checked %0d readouts, %0d with seconds wrap, over %0d register writes",
               tracker.checked, tracker.wraps, tracker.reg_writes);
      if (tracker.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== base_thousand_time_counter.f =====
sv/btc_pkg.sv
sv/btc_split.sv
sv/btc_total.sv
sv/base_thousand_time_counter.sv
sv/btc_check.sv
tb/sv/tb_top.sv
